[src/pse_pkg.sv]
package pse_pkg;

  // word width of the operand stack and of the data path
  localparam int DATA_W = 32;
  localparam int OP_W = 4;
  localparam int STATUS_W = 3;
  localparam int DEFAULT_STACK_DEPTH = 16;

  // operator codes carried on the input tuser
  localparam logic [OP_W-1:0] OP_PUSH = 4'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 4'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 4'd4;
  localparam logic [OP_W-1:0] OP_MOD  = 4'd5;
  localparam logic [OP_W-1:0] OP_XOR  = 4'd6;
  localparam logic [OP_W-1:0] OP_OR   = 4'd7;
  localparam logic [OP_W-1:0] OP_AND  = 4'd8;
  localparam logic [OP_W-1:0] OP_SHL  = 4'd9;
  localparam logic [OP_W-1:0] OP_SHR  = 4'd10;
  localparam logic [OP_W-1:0] OP_NOT  = 4'd11;

  // status codes carried on the output tuser
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NORESULT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_COMMIT
  } state_t;

  // effect of one token on the stack
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_POP,
    ACT_REPLACE
  } act_t;

  // what one stack cell loads at the clock edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_NEW,
    CELL_UP,
    CELL_DOWN
  } cell_cmd_t;

endpackage

[src/pse_cell.sv]
module pse_cell (
  input  logic                      clk,
  input  pse_pkg::cell_cmd_t        cmd,
  input  logic [pse_pkg::DATA_W-1:0] new_data,
  input  logic [pse_pkg::DATA_W-1:0] up_data,
  input  logic [pse_pkg::DATA_W-1:0] down_data,
  output logic [pse_pkg::DATA_W-1:0] data
);
  import pse_pkg::*;

  // one stack word: loads a new top, or takes the neighbor word on push or pop
  always_ff @(posedge clk) begin
    case (cmd)
      CELL_NEW:  data <= new_data;
      CELL_UP:   data <= up_data;
      CELL_DOWN: data <= down_data;
      default:   data <= data;
    endcase
  end

endmodule

[src/pse_divider.sv]
module pse_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pse_pkg::DATA_W-1:0] dividend,
  input  logic [pse_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [pse_pkg::DATA_W-1:0] quotient,
  output logic [pse_pkg::DATA_W-1:0] remainder
);
  import pse_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] divisor_q;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] diff;

  // one restoring step: shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem, quo[DATA_W-1]};
    diff    = {1'b0, shifted} - {2'b00, divisor_q};
  end

  // control of the bit loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient, one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      divisor_q <= divisor;
      rem       <= '0;
      quo       <= dividend;
    end else if (busy) begin
      if (diff[DATA_W+1]) begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end else begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[src/postfix_stack_evaluator.sv]
// channel | dir | tdata            | tuser       | tlast
// s       | in  | operand [31:0]   | op [3:0]    | last
// m       | out | step_value[31:0] | status[2:0] | final_res
//
// a token passes through accept, execute and commit; div and mod wait
// in a divide state on the serial divider, one quotient bit per cycle.
// the stack is a row of cells, top word in cell 0; push and pop shift the row.
// one token is in work at a time; the next is accepted while a result waits
// in the output register. rst is synchronous and empties the stack.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [pse_pkg::DATA_W-1:0]   s_tdata,   // operand
  input  logic [pse_pkg::OP_W-1:0]     s_tuser,   // op
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [pse_pkg::DATA_W-1:0]   m_tdata,   // step_value
  output logic [pse_pkg::STATUS_W-1:0] m_tuser,   // status
  output logic                         m_tlast
);
  import pse_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  state_t state;
  state_t state_next;

  logic [OP_W-1:0]     op_q;
  logic [DATA_W-1:0]   operand_q;
  logic                last_q;
  logic [STATUS_W-1:0] st_q;
  act_t                act_q;
  logic                mod_q;
  logic [DATA_W-1:0]   res_q;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                error_seen;

  logic [DATA_W-1:0] cell_q [STACK_DEPTH];
  logic [DATA_W-1:0] top;
  logic [DATA_W-1:0] second;

  logic                exec_div;
  logic [STATUS_W-1:0] exec_st;
  act_t                exec_act;
  logic [DATA_W-1:0]   exec_res;

  logic              out_free;
  logic              accept;
  logic              commit;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic [DATA_W-1:0] div_rem;
  logic [DATA_W-1:0] top_after;
  logic [DATA_W-1:0] out_data;
  logic [STATUS_W-1:0] out_st;

  assign top    = cell_q[0];
  assign second = cell_q[1];

  // classify the held token against the stack and compute its value
  always_comb begin
    exec_st  = ST_OK;
    exec_act = ACT_NONE;
    exec_res = '0;
    exec_div = 1'b0;
    if (error_seen) begin
      exec_st = last_q ? ST_NORESULT : ST_OK;
    end else if (op_q == OP_PUSH) begin
      if (count >= CNT_W'(STACK_DEPTH)) begin
        exec_st = ST_OVERFLOW;
      end else begin
        exec_act = ACT_PUSH;
        exec_res = operand_q;
      end
    end else if (op_q == OP_NOT) begin
      if (count == '0) begin
        exec_st = ST_MISSING;
      end else begin
        exec_act = ACT_REPLACE;
        exec_res = ~top;
      end
    end else if (op_q >= OP_ADD && op_q <= OP_SHR) begin
      if (count < CNT_W'(2)) begin
        exec_st = ST_MISSING;
      end else if ((op_q == OP_DIV || op_q == OP_MOD) && top == '0) begin
        exec_st = ST_DIVZERO;
      end else begin
        exec_act = ACT_POP;
        case (op_q)
          OP_ADD:  exec_res = second + top;
          OP_SUB:  exec_res = second - top;
          OP_MUL:  exec_res = second * top;
          OP_XOR:  exec_res = second ^ top;
          OP_OR:   exec_res = second | top;
          OP_AND:  exec_res = second & top;
          OP_SHL:  exec_res = second << top[4:0];
          OP_SHR:  exec_res = second >> top[4:0];
          default: exec_div = 1'b1;
        endcase
      end
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_EXEC;
      S_EXEC:   state_next = exec_div ? S_DIV : S_COMMIT;
      S_DIV:    if (div_done) state_next = S_COMMIT;
      S_COMMIT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    commit    = 1'b0;
    case (state)
      S_IDLE:   s_tready = 1'b1;
      S_EXEC:   div_start = exec_div;
      S_COMMIT: commit = out_free;
      default:  s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // token and result holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= s_tuser;
      operand_q <= s_tdata;
      last_q    <= s_tlast;
    end
    if (state == S_EXEC) begin
      st_q  <= exec_st;
      act_q <= exec_act;
      mod_q <= (op_q == OP_MOD);
      res_q <= exec_res;
    end else if (div_done) begin
      res_q <= mod_q ? div_rem : div_quo;
    end
  end

  pse_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (second),
    .divisor   (top),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // stack depth after this token
  always_comb begin
    case (act_q)
      ACT_PUSH: count_next = count + 1'b1;
      ACT_POP:  count_next = count - 1'b1;
      default:  count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      error_seen <= 1'b0;
    end else if (commit) begin
      if (last_q) begin
        count      <= '0;
        error_seen <= 1'b0;
      end else begin
        count <= count_next;
        if (st_q != ST_OK) error_seen <= 1'b1;
      end
    end
  end

  // row of stack cells, cell 0 holds the top word
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] up_data;
    logic [DATA_W-1:0] down_data;
    cell_cmd_t         cmd;

    if (i == 0) begin : g_first
      assign up_data = res_q;
    end else begin : g_mid
      assign up_data = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_end
      assign down_data = cell_q[i];
    end else begin : g_inner
      assign down_data = cell_q[i+1];
    end

    always_comb begin
      cmd = CELL_HOLD;
      if (commit) begin
        case (act_q)
          ACT_PUSH:    cmd = (i == 0) ? CELL_NEW : CELL_UP;
          ACT_POP:     cmd = (i == 0) ? CELL_NEW : CELL_DOWN;
          ACT_REPLACE: cmd = (i == 0) ? CELL_NEW : CELL_HOLD;
          default:     cmd = CELL_HOLD;
        endcase
      end
    end

    pse_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .new_data  (res_q),
      .up_data   (up_data),
      .down_data (down_data),
      .data      (cell_q[i])
    );
  end

  // result beat: step value, final top of stack on the last token, or zero
  always_comb begin
    top_after = (act_q == ACT_NONE) ? top : res_q;
    out_st    = st_q;
    out_data  = '0;
    if (st_q == ST_OK) begin
      if (last_q) begin
        if (count_next == '0) out_st = ST_NORESULT;
        else                  out_data = top_after;
      end else if (act_q != ACT_NONE) begin
        out_data = res_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= out_data;
      m_tuser <= out_st;
      m_tlast <= last_q;
    end
  end

  // depth never passes the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // an accepted token goes straight to execution
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted token not executed");

  // the divider only reports while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside divide wait");

  // an error beat carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> m_tdata == '0)
    else $error("error beat with nonzero value");

  // closing the expression empties the stack
  a_last_clear: assert property (@(posedge clk) disable iff (rst)
    (commit && last_q) |=> (count == '0 && !error_seen))
    else $error("stack not cleared after last token");

endmodule
